[sv/hpid_pkg.sv]
package hpid_pkg;

  // field widths
  localparam int ANGLE_W   = 9;
  localparam int GAIN_W    = 16;
  localparam int DT_W      = 20;
  localparam int INTEG_W   = 48;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 2;

  // shared multiplier and divider widths
  localparam int MUL_W     = 24;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_NUM_W = 36;
  localparam int DIV_DEN_W = DT_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic signed [10:0] HALF_TURN = 11'sd180;
  localparam logic signed [10:0] FULL_TURN = 11'sd360;
  localparam logic [6:0] I_LIMIT = 7'd50;
  localparam logic [DT_W-1:0] US_PER_S = 20'd1000000;
  // one count above the limit is enough to know the integral term clamps
  localparam logic [DIV_NUM_W-1:0] I_DIVIDEND_CAP = 36'd51000000;

  // integral scale: x / 1000000 as (x >> 6) / 15625 by reciprocal multiply,
  // exact for every capped dividend
  localparam int I_PRE_SHIFT   = 6;
  localparam int I_RECIP_SHIFT = 34;
  localparam int I_QUO_W       = PROD_W - I_RECIP_SHIFT;
  localparam logic [MUL_W-1:0] I_RECIP = 24'd1099512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_AVG,
    ST_ACC,
    ST_P_TERM,
    ST_I_LO,
    ST_I_HI,
    ST_I_SCALE,
    ST_D_MUL,
    ST_D_START,
    ST_D_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

[sv/heading_pid_with_angle_wrap.sv]
// heading pid controller: one result beat for every input beat
// most of the time from input accept to out_valid goes to the bit-serial divider
//   pass for the derivative term
// in_ready is high only while idle: a new item is not taken until the last one
// is through; a finished result waits in its own register, so the next item may start
// reset (synchronous, rst high): gains, target, previous error and integral cleared
module heading_pid_with_angle_wrap import hpid_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [ANGLE_W-1:0]   heading,
  input  logic        [DT_W-1:0]      elapsed_us,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_W-1:0]     drive_correction,
  input  logic                        cfg_we,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [GAIN_W-1:0]    cfg_data
);

  // configuration registers
  logic signed [ANGLE_W-1:0] target;
  logic signed [GAIN_W-1:0]  gain_p;
  logic signed [GAIN_W-1:0]  gain_i;
  logic signed [GAIN_W-1:0]  gain_d;

  // loop state
  logic signed [ANGLE_W-1:0] prev_err;
  logic signed [INTEG_W-1:0] integ;

  // per-item working registers
  state_t                    state, state_next;
  logic signed [ANGLE_W-1:0] e1;
  logic signed [ANGLE_W-1:0] e0;
  logic        [DT_W-1:0]    dt;
  logic signed [OUT_W-1:0]   p_term;
  logic signed [6:0]         i_term;
  logic        [39:0]        lo_acc;

  // shared units
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // error forming
  logic signed [10:0]        gap;
  logic signed [10:0]        wrapped;
  logic signed [ANGLE_W-1:0] e_new;
  logic signed [9:0]         err_sum;
  logic signed [9:0]         err_diff;
  logic        [9:0]         sum_mag;
  logic        [9:0]         diff_abs;
  logic        [7:0]         avg_mag;
  logic        [8:0]         diff_mag;
  logic        [8:0]         e1_mag;
  logic        [GAIN_W-1:0]  gp_mag;
  logic        [GAIN_W-1:0]  gi_mag;
  logic        [GAIN_W-1:0]  gd_mag;
  logic        [INTEG_W-1:0] integ_mag;
  logic                      avg_neg;
  logic                      p_neg;
  logic                      i_neg;
  logic                      d_neg;

  // integral update
  logic signed [29:0]        addend;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_sat;

  // term shaping
  logic signed [OUT_W-1:0]   p_mag;
  logic        [63:0]        i_full;
  logic        [55:0]        i_scaled;
  logic        [DIV_NUM_W-1:0] i_dividend;
  logic        [I_QUO_W-1:0] i_quo;
  logic        [6:0]         i_mag;
  logic                      d_big;
  logic signed [18:0]        d_val;
  logic signed [18:0]        total;
  logic signed [OUT_W-1:0]   total_sat;

  hpid_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  hpid_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready = (state == ST_IDLE);

  // heading error with a single wrap step; the result always lands in -180..180
  always_comb begin
    gap = {{2{heading[ANGLE_W-1]}}, heading} - {{2{target[ANGLE_W-1]}}, target};
    if (gap > HALF_TURN) begin
      wrapped = gap - FULL_TURN;
    end else if (gap < -HALF_TURN) begin
      wrapped = gap + FULL_TURN;
    end else begin
      wrapped = gap;
    end
    e_new = wrapped[ANGLE_W-1:0];
  end

  // magnitudes and signs, every product runs unsigned on the shared multiplier
  always_comb begin
    err_sum   = {e1[ANGLE_W-1], e1} + {e0[ANGLE_W-1], e0};
    err_diff  = {e1[ANGLE_W-1], e1} - {e0[ANGLE_W-1], e0};
    sum_mag   = err_sum[9] ? 10'(-err_sum) : 10'(err_sum);
    diff_abs  = err_diff[9] ? 10'(-err_diff) : 10'(err_diff);
    avg_mag   = sum_mag[8:1];  // halving of the magnitude truncates toward zero
    diff_mag  = diff_abs[8:0];
    avg_neg   = err_sum[9];
    e1_mag    = e1[ANGLE_W-1] ? 9'(-e1) : 9'(e1);
    gp_mag    = gain_p[GAIN_W-1] ? GAIN_W'(-gain_p) : GAIN_W'(gain_p);
    gi_mag    = gain_i[GAIN_W-1] ? GAIN_W'(-gain_i) : GAIN_W'(gain_i);
    gd_mag    = gain_d[GAIN_W-1] ? GAIN_W'(-gain_d) : GAIN_W'(gain_d);
    integ_mag = integ[INTEG_W-1] ? INTEG_W'(-integ) : INTEG_W'(integ);
    p_neg     = gain_p[GAIN_W-1] ^ e1[ANGLE_W-1];
    i_neg     = gain_i[GAIN_W-1] ^ integ[INTEG_W-1];
    d_neg     = gain_d[GAIN_W-1] ^ err_diff[9];
  end

  // trapezoid step added to the integral, saturating at 48 bits
  always_comb begin
    addend    = avg_neg ? -$signed({1'b0, prod[28:0]}) : $signed({1'b0, prod[28:0]});
    integ_sum = {integ[INTEG_W-1], integ} + {{(INTEG_W - 29){addend[29]}}, addend};
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                     : {1'b0, {(INTEG_W - 1){1'b1}}};
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end
  end

  // proportional, integral and derivative terms from the shared units
  always_comb begin
    p_mag      = {1'b0, prod[22:8]};
    // gain_i times integral from two 24-bit halves, then drop the Q8.8 fraction
    i_full     = {prod[39:0], 24'b0} + {24'b0, lo_acc};
    i_scaled   = i_full[63:8];
    i_dividend = (i_scaled >= 56'(I_DIVIDEND_CAP)) ? I_DIVIDEND_CAP
                                                   : i_scaled[DIV_NUM_W-1:0];
    // whole seconds of the scaled integral, from the reciprocal product
    i_quo      = prod[PROD_W-1:I_RECIP_SHIFT];
    i_mag      = (i_quo > I_QUO_W'(I_LIMIT)) ? I_LIMIT : i_quo[6:0];
    // a derivative this large saturates the sum whatever the other terms are
    d_big      = |div_rsp.quotient[DIV_NUM_W-1:17];
    d_val      = d_neg ? -$signed({2'b0, div_rsp.quotient[16:0]})
                       : $signed({2'b0, div_rsp.quotient[16:0]});
    total      = {{3{p_term[OUT_W-1]}}, p_term} + {{12{i_term[6]}}, i_term} + d_val;
    if (d_big) begin
      total_sat = d_neg ? {1'b1, {(OUT_W - 1){1'b0}}} : {1'b0, {(OUT_W - 1){1'b1}}};
    end else if (total > 19'sd32767) begin
      total_sat = {1'b0, {(OUT_W - 1){1'b1}}};
    end else if (total < -19'sd32768) begin
      total_sat = {1'b1, {(OUT_W - 1){1'b0}}};
    end else begin
      total_sat = total[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: picks multiplier operands and starts divides
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_req    = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MUL_AVG;
        end
      end
      ST_MUL_AVG: begin
        mul_a      = MUL_W'(avg_mag);
        mul_b      = MUL_W'(dt);
        state_next = ST_ACC;
      end
      ST_ACC: begin
        mul_a      = MUL_W'(gp_mag);
        mul_b      = MUL_W'(e1_mag);
        state_next = ST_P_TERM;
      end
      ST_P_TERM: begin
        mul_a      = MUL_W'(gi_mag);
        mul_b      = integ_mag[MUL_W-1:0];
        state_next = ST_I_LO;
      end
      ST_I_LO: begin
        mul_a      = MUL_W'(gi_mag);
        mul_b      = integ_mag[INTEG_W-1:MUL_W];
        state_next = ST_I_HI;
      end
      ST_I_HI: begin
        // capped dividend fits 20 bits once the low six are dropped
        mul_a      = MUL_W'(i_dividend[DIV_NUM_W-1:I_PRE_SHIFT]);
        mul_b      = I_RECIP;
        state_next = ST_I_SCALE;
      end
      ST_I_SCALE: begin
        mul_a      = MUL_W'(gd_mag);
        mul_b      = MUL_W'(diff_mag);
        state_next = ST_D_MUL;
      end
      ST_D_MUL: begin
        mul_a      = prod[MUL_W-1:0];
        mul_b      = MUL_W'(US_PER_S);
        state_next = ST_D_START;
      end
      ST_D_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[43:8];
        div_req.divisor  = dt;
        state_next       = ST_D_DIV;
      end
      ST_D_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait until the previous result beat has gone
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration, loop state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      target    <= '0;
      gain_p    <= '0;
      gain_i    <= '0;
      gain_d    <= '0;
      prev_err  <= '0;
      integ     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_TARGET: target <= cfg_data[ANGLE_W-1:0];
          REG_GAIN_P: gain_p <= cfg_data;
          REG_GAIN_I: gain_i <= cfg_data;
          REG_GAIN_D: gain_d <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        prev_err <= e_new;
      end
      if (state == ST_ACC) begin
        integ <= integ_sat;
      end
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      e1 <= e_new;
      e0 <= prev_err;
      // a zero period counts as one microsecond
      dt <= (elapsed_us == '0) ? DT_W'(1) : elapsed_us;
    end
    if (state == ST_P_TERM) begin
      p_term <= p_neg ? -p_mag : p_mag;
    end
    if (state == ST_I_LO) begin
      lo_acc <= prod[39:0];
    end
    if (state == ST_I_SCALE) begin
      i_term <= i_neg ? -$signed(i_mag) : $signed(i_mag);
    end
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      drive_correction <= total_sat;
    end
  end

endmodule

[sv/hpid_mul.sv]
module hpid_mul import hpid_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] prod
);

  // unsigned multiply, product registered
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

[sv/hpid_div.sv]
module hpid_div import hpid_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  // restoring division, one quotient bit a cycle
  assign shifted = {rem, quo[DIV_NUM_W-1]};
  assign trial   = shifted - {1'b0, den};
  assign ge      = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      den <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_NUM_W-2:0], ge};
      rem <= ge ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import hpid_pkg::*;

  // arithmetic constants of the control law, kept wide so nothing overflows
  localparam longint DEG_HALF     = 180;
  localparam longint DEG_FULL     = 360;
  localparam longint I_CLAMP      = 50;
  localparam longint US_PER_SEC   = 1000000;
  localparam longint Q8_ONE       = 256;
  localparam longint INTEG_TOP    = (64'sd1 <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_BOTTOM = -(64'sd1 <<< (INTEG_W - 1));

  // tracks the controller state on the side and holds the corrections still due
  class correction_tracker;
    logic signed [ANGLE_W-1:0] target_deg;
    logic signed [GAIN_W-1:0]  kp, ki, kd;
    longint                    prev_err;
    longint                    integ;
    logic signed [OUT_W-1:0]   due_corrections[$];
    int                        mismatches;
    int                        beats_in;
    int                        results_seen;

    function new();
      target_deg   = '0;
      kp           = '0;
      ki           = '0;
      kd           = '0;
      prev_err     = 0;
      integ        = 0;
      mismatches   = 0;
      beats_in     = 0;
      results_seen = 0;
    endfunction

    // mirror of a register write; only the low bits of the target are kept
    function void set_reg(reg_idx_t idx, logic [GAIN_W-1:0] data);
      case (idx)
        REG_TARGET: target_deg = data[ANGLE_W-1:0];
        REG_GAIN_P: kp = data;
        REG_GAIN_I: ki = data;
        REG_GAIN_D: kd = data;
        default: ;
      endcase
    endfunction

    // one accepted heading beat -> one expected correction
    function void note_heading(logic signed [ANGLE_W-1:0] hd, logic [DT_W-1:0] period);
      longint dt, gap, err, p_term, i_term, d_term, total;
      // a zero period counts as one microsecond
      dt = (period == '0) ? 64'sd1 : longint'(period);
      // single wrap step, then clamp whatever is still outside a half turn
      gap = longint'(hd) - longint'(target_deg);
      if (gap > DEG_HALF) gap -= DEG_FULL;
      else if (gap < -DEG_HALF) gap += DEG_FULL;
      err = (gap > DEG_HALF) ? DEG_HALF : ((gap < -DEG_HALF) ? -DEG_HALF : gap);
      // trapezoid in degree-microseconds, truncating halving, 48-bit saturation
      integ += ((err + prev_err) / 2) * dt;
      if (integ > INTEG_TOP) integ = INTEG_TOP;
      else if (integ < INTEG_BOTTOM) integ = INTEG_BOTTOM;
      p_term = (longint'(kp) * err) / Q8_ONE;
      i_term = (longint'(ki) * integ) / (Q8_ONE * US_PER_SEC);
      if (i_term > I_CLAMP) i_term = I_CLAMP;
      else if (i_term < -I_CLAMP) i_term = -I_CLAMP;
      d_term = (longint'(kd) * (err - prev_err) * US_PER_SEC) / (Q8_ONE * dt);
      total = p_term + i_term + d_term;
      if (total > 32767) total = 32767;
      else if (total < -32768) total = -32768;
      due_corrections.push_back(total[OUT_W-1:0]);
      prev_err = err;
      beats_in++;
    endfunction

    function void check_drive(logic signed [OUT_W-1:0] got);
      logic signed [OUT_W-1:0] want;
      results_seen++;
      if (due_corrections.size() == 0) begin
        $error("drive_correction: expected nothing, got %0d", got);
        mismatches++;
        return;
      end
      want = due_corrections.pop_front();
      if (got !== want) begin
        $error("drive_correction: expected %0d, got %0d", want, got);
        mismatches++;
      end
    endfunction

    function int pending();
      return due_corrections.size();
    endfunction

    function void close_out();
      if (due_corrections.size() != 0) begin
        $error("drive_correction: expected %0d more beats, got none",
               due_corrections.size());
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [ANGLE_W-1:0] heading;
  logic [DT_W-1:0] elapsed_us;
  logic out_valid;
  logic out_ready;
  logic signed [OUT_W-1:0] drive_correction;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0] cfg_data;

  correction_tracker sb = new();

  // idle percentages for each side, switched by the main sequence
  int send_idle = 38;
  int recv_idle = 53;
  // long receiver hold-off, requested by the main sequence, counted by the receiver
  bit stall_req = 1'b0;
  int stall_len = 0;
  int settings  = 0;

  heading_pid_with_angle_wrap dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .heading          (heading),
    .elapsed_us       (elapsed_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .drive_correction (drive_correction),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // offer one heading beat after a random gap and hold it until accepted;
  // valid is left high so a following beat can go straight out
  task automatic send_heading(input int deg, input int period);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    heading    <= deg[ANGLE_W-1:0];
    elapsed_us <= period[DT_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_heading(heading, elapsed_us);
  endtask

  // stop offering and let every outstanding correction come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers back to back, only ever while the block is idle
  task automatic program_regs(input logic [GAIN_W-1:0] tgt, gp, gi, gd);
    logic [GAIN_W-1:0] vals [4];
    reg_idx_t idx;
    vals = '{tgt, gp, gi, gd};
    for (int k = 0; k < 4; k++) begin
      idx = reg_idx_t'(k);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[k];
      @(posedge clk);
      sb.set_reg(idx, vals[k]);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  // target word: the low 9 bits carry the angle, the upper bits are junk the block drops
  function automatic logic [GAIN_W-1:0] tgt_word(input int deg);
    logic [GAIN_W-1:0] word;
    word = GAIN_W'($urandom);
    word[ANGLE_W-1:0] = deg[ANGLE_W-1:0];
    return word;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    int g;
    case ($urandom_range(6))
      0: g = -32768;
      1: g = 32767;
      2: g = 0;
      3: g = $urandom;
      4: g = int'($urandom_range(16384)) - 8192;
      default: g = int'($urandom_range(2048)) - 1024;
    endcase
    return g[GAIN_W-1:0];
  endfunction

  // mostly millisecond-ish loop periods, with the corners sprinkled in
  function automatic int pick_period();
    case ($urandom_range(15))
      0: return 0;
      1: return 1;
      2: return (1 << DT_W) - 1;
      3: return $urandom_range((1 << DT_W) - 1);
      4: return $urandom_range(64);
      default: return $urandom_range(20000, 200);
    endcase
  endfunction

  // a block of random beats: mostly a heading drifting around the compass,
  // now and then a jump or any value the 9-bit field can hold
  task automatic run_block(input int n_items, input bit with_hold);
    int walk;
    int deg;
    walk = int'($urandom_range(360)) - 180;
    for (int k = 0; k < n_items; k++) begin
      if (with_hold && k == n_items / 2) begin
        stall_len = 300 + $urandom_range(300);
        stall_req = 1'b1;
      end
      case ($urandom_range(9))
        0: deg = int'($urandom_range(511)) - 256;
        1: deg = int'($urandom_range(360)) - 180;
        default: begin
          walk += int'($urandom_range(20)) - 10;
          if (walk > 180) walk -= 360;
          else if (walk < -180) walk += 360;
          deg = walk;
        end
      endcase
      send_heading(deg, pick_period());
    end
    wait_idle();
  endtask

  // receiver: checks every correction beat, idles at random, honours long holds
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_drive(drive_correction);
      if (stall_req) begin
        hold_left = stall_len;
        stall_req = 1'b0;
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // main sequence
  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    heading    = '0;
    elapsed_us = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_TARGET;
    cfg_data   = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: all gains zero, so every correction is zero
    send_heading(90, 1000);
    send_heading(-45, 0);
    wait_idle();

    // unity gains, target straight ahead: compass extremes, zero and full-scale periods
    program_regs(tgt_word(0), 16'h0100, 16'h0100, 16'h0100);
    send_heading(180, 1000);
    send_heading(-180, 0);
    send_heading(0, (1 << DT_W) - 1);
    send_heading(255, 1);
    send_heading(-256, 500);
    send_heading(45, 20000);
    wait_idle();

    // largest positive gains, periods of 1 or 3 microseconds: sum saturates both ways
    program_regs(tgt_word(-180), 16'h7fff, 16'h7fff, 16'h7fff);
    send_heading(180, 1);
    send_heading(0, 1);
    send_heading(-1, 1);
    send_heading(-180, 3);
    wait_idle();

    // most negative gains with the opposite target; a full turn wraps to zero
    program_regs(tgt_word(180), 16'h8000, 16'h8000, 16'h8000);
    send_heading(-180, 1);
    send_heading(0, 7);
    send_heading(179, 2);
    send_heading(-256, 9);
    wait_idle();

    // targets beyond the compass range, errors still land inside a half turn
    program_regs(tgt_word(255), 16'h0080, 16'hff00, 16'h0001);
    send_heading(-256, 100);
    send_heading(255, 100);
    send_heading(-1, 0);
    wait_idle();
    program_regs(tgt_word(-256), pick_gain(), pick_gain(), pick_gain());
    send_heading(255, (1 << DT_W) - 1);
    send_heading(-256, 1);
    wait_idle();

    // random part: three idle regimes, four register settings in each
    for (int b = 0; b < 12; b++) begin
      send_idle = (b < 4) ? 38 : ((b < 8) ? 53 : 0);
      recv_idle = (b < 4) ? 53 : ((b < 8) ? 38 : 0);
      case (b % 4)
        0: program_regs(tgt_word(-180), 16'h7fff, 16'h7fff, 16'h7fff);
        1: program_regs(tgt_word(180), 16'h8000, 16'h8000, 16'h8000);
        default: begin
          if ($urandom_range(3) == 0)
            program_regs(tgt_word(int'($urandom_range(511)) - 256),
                         pick_gain(), pick_gain(), pick_gain());
          else
            program_regs(tgt_word(int'($urandom_range(360)) - 180),
                         pick_gain(), pick_gain(), pick_gain());
        end
      endcase
      // long receiver hold-offs in two of the blocks while the sender keeps pushing
      run_block(140, (b == 1) || (b == 9));
    end

    // let anything stray surface before closing out
    repeat (100) @(posedge clk);
    sb.close_out();

    $display("%0d heading beats sent, %0d correction beats checked, %0d register settings",
             sb.beats_in, sb.results_seen, settings);
    $display("covered zero and full-scale periods, off-compass headings and targets, gain extremes");
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #40000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
sv/hpid_pkg.sv
sv/hpid_mul.sv
sv/hpid_div.sv
sv/heading_pid_with_angle_wrap.sv
tb/sv/tb.sv
